/* design/sexpr_token_scanner_macros.svh */
// ----------------------------------------------------------------------------
// sexpr_token_scanner_macros
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef SEXPR_TOKEN_SCANNER_MACROS_SVH
`define SEXPR_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define STS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sexpr_token_scanner: assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define STS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sexpr_token_scanner: assertion failed");

`endif

/* design/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// types, codes and byte classes of the s-expression token scanner
// ----------------------------------------------------------------------------
package sts_pkg;

    typedef enum logic [2:0] {
        KIND_END    = 3'd0,
        KIND_LPAREN = 3'd1,
        KIND_RPAREN = 3'd2,
        KIND_BOOL   = 3'd3,
        KIND_INT    = 3'd4,
        KIND_SYM    = 3'd5,
        KIND_ERROR  = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_INT  = 3'd1,
        MODE_SYM  = 3'd2,
        MODE_HASH = 3'd3,
        MODE_SKIP = 3'd4
    } t_mode;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SYM_LO = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_T   = 8'h54;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_SYM_HI = 8'h7E;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // token start and length on the result bus
    localparam int TDATA_BITS = 32;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
        t_mode      next_mode;
        logic       set_start;
    } t_scan;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sym_byte(input logic [7:0] c);
        return (c >= CH_SYM_LO) && (c <= CH_SYM_HI) && (c != CH_LPAREN) && (c != CH_RPAREN);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

endpackage

/* design/sexpr_token_scanner.sv */
// ----------------------------------------------------------------------------
// sexpr_token_scanner
// byte-serial lexer for s-expression text, one token result per output item
// ----------------------------------------------------------------------------
//  channel   dir   item                        tdata / tuser / tlast
//  s_axis    in    one source byte             tdata[7:0] text_byte
//  m_axis    out   one token result            tdata start, length; tuser kind; tlast
//
//  one byte per cycle; a byte that gives two results puts both into the
//  two-entry result queue, which sends them out one item at a time.
//  the byte is registered in the input register and its results are
//  registered in the result queue, from which they leave.
//  synchronous active-low reset clears the scan mode, position and queues.
//  a stalled output holds its item; input keeps flowing while the queue has room.
// ----------------------------------------------------------------------------
module sexpr_token_scanner #(
    parameter int POSITION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sts_pkg::TDATA_BITS-1:0] m_axis_tdata,   // [15:0] token_start,
                                                           // [31:16] token_length
    output logic [2:0]                     m_axis_tuser,   // [2:0] token_kind
    output logic                           m_axis_tlast    // last_of_run
);

    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    sts_pkg::t_mode           r_mode;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_open_start;
    logic [1:0]               r_cnt;
    sts_pkg::t_result         r_slot0;
    sts_pkg::t_result         r_slot1;

    logic [1:0]               n_cnt;
    sts_pkg::t_result         n_slot0;
    sts_pkg::t_result         n_slot1;

    sts_pkg::t_scan           scan;
    logic [POSITION_BITS-1:0] next_pos;
    logic                     pop;
    logic [1:0]               room;
    logic                     consume;
    logic [1:0]               push_n;
    logic [1:0]               rem;
    sts_pkg::t_result         head_rem;

    sts_classify #(
        .POSITION_BITS(POSITION_BITS)
    ) u_classify (
        .i_byte      (r_in_byte),
        .i_mode      (r_mode),
        .i_pos       (r_pos),
        .i_open_start(r_open_start),
        .o_scan      (scan),
        .o_next_pos  (next_pos)
    );

    assign pop     = (r_cnt != 2'd0) && m_axis_tready;
    assign room    = 2'(2'd2 - r_cnt + {1'b0, pop});
    assign consume = r_in_valid && (scan.num <= room);
    assign push_n  = consume ? scan.num : 2'd0;
    assign rem     = 2'(r_cnt - {1'b0, pop});
    assign head_rem = pop ? r_slot1 : r_slot0;

    assign s_axis_tready = !r_in_valid || consume;

    // queue refill: survivors first, new results after them
    always_comb begin
        n_cnt = 2'(rem + push_n);
        if (rem == 2'd0) begin
            n_slot0 = scan.res0;
            n_slot1 = scan.res1;
        end else if (rem == 2'd1) begin
            n_slot0 = head_rem;
            n_slot1 = scan.res0;
        end else begin
            n_slot0 = r_slot0;
            n_slot1 = r_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_mode       <= sts_pkg::MODE_IDLE;
            r_pos        <= '0;
            r_open_start <= '0;
            r_cnt        <= 2'd0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_mode <= scan.next_mode;
                r_pos  <= next_pos;
                if (scan.set_start) begin
                    r_open_start <= r_pos;
                end
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {r_slot0.length, r_slot0.start};
    assign m_axis_tuser  = r_slot0.kind;
    assign m_axis_tlast  = r_slot0.last;

endmodule

/* design/sts_classify.sv */
// ----------------------------------------------------------------------------
// sts_classify
// per-byte decode: results caused by one byte and the next scan state
// ----------------------------------------------------------------------------
module sts_classify #(
    parameter int POSITION_BITS = 16
) (
    input  logic [7:0]               i_byte,
    input  sts_pkg::t_mode           i_mode,
    input  logic [POSITION_BITS-1:0] i_pos,
    input  logic [POSITION_BITS-1:0] i_open_start,
    output sts_pkg::t_scan           o_scan,
    output logic [POSITION_BITS-1:0] o_next_pos
);

    localparam int SW = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    function automatic logic [15:0] sat16(input logic [POSITION_BITS-1:0] v);
        logic [SW-1:0] w;
        w = SW'(v);
        return (w > SW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    logic [7:0]      c;
    logic [15:0]     pos_sat;
    logic [15:0]     start_sat;
    logic [15:0]     len_sat;
    logic            idle_hit;
    sts_pkg::t_kind  idle_kind;
    logic [15:0]     idle_len;
    sts_pkg::t_mode  idle_mode;
    logic            idle_set;
    sts_pkg::t_result idle_res;
    logic            cont;
    sts_pkg::t_scan  scan;

    assign c         = sts_pkg::fold_upper(i_byte);
    assign pos_sat   = sat16(i_pos);
    assign start_sat = sat16(i_open_start);
    assign len_sat   = sat16(i_pos - i_open_start);

    // handling of a byte seen between tokens
    always_comb begin
        idle_hit  = 1'b0;
        idle_kind = sts_pkg::KIND_ERROR;
        idle_len  = 16'd0;
        idle_mode = sts_pkg::MODE_IDLE;
        idle_set  = 1'b0;
        if (c == sts_pkg::CH_NUL) begin
            idle_hit  = 1'b1;
            idle_kind = sts_pkg::KIND_END;
        end else if (sts_pkg::is_space(c)) begin
            idle_hit = 1'b0;
        end else if (c == sts_pkg::CH_LPAREN) begin
            idle_hit  = 1'b1;
            idle_kind = sts_pkg::KIND_LPAREN;
            idle_len  = 16'd1;
        end else if (c == sts_pkg::CH_RPAREN) begin
            idle_hit  = 1'b1;
            idle_kind = sts_pkg::KIND_RPAREN;
            idle_len  = 16'd1;
        end else if (c == sts_pkg::CH_HASH) begin
            idle_mode = sts_pkg::MODE_HASH;
            idle_set  = 1'b1;
        end else if (sts_pkg::is_digit(c)) begin
            idle_mode = sts_pkg::MODE_INT;
            idle_set  = 1'b1;
        end else if (sts_pkg::is_sym_byte(c)) begin
            idle_mode = sts_pkg::MODE_SYM;
            idle_set  = 1'b1;
        end else begin
            idle_hit  = 1'b1;
            idle_kind = sts_pkg::KIND_ERROR;
            idle_mode = sts_pkg::MODE_SKIP;
        end
    end

    assign idle_res = '{kind: idle_kind, start: pos_sat, length: idle_len, last: 1'b0};
    assign cont = (i_mode == sts_pkg::MODE_INT) ? sts_pkg::is_digit(c) : sts_pkg::is_sym_byte(c);

    always_comb begin
        scan.num       = 2'd0;
        scan.res0      = idle_res;
        scan.res1      = idle_res;
        scan.next_mode = i_mode;
        scan.set_start = 1'b0;
        case (i_mode)
            sts_pkg::MODE_HASH: begin
                if (c == sts_pkg::CH_UP_T || c == sts_pkg::CH_UP_F) begin
                    scan.num       = 2'd1;
                    scan.res0      = '{kind: sts_pkg::KIND_BOOL, start: start_sat,
                                       length: 16'd2, last: 1'b0};
                    scan.next_mode = sts_pkg::MODE_IDLE;
                end else begin
                    // bad boolean; an end byte here also ends the text
                    scan.num       = (c == sts_pkg::CH_NUL) ? 2'd2 : 2'd1;
                    scan.res0      = '{kind: sts_pkg::KIND_ERROR, start: pos_sat,
                                       length: 16'd0, last: 1'b0};
                    scan.res1      = '{kind: sts_pkg::KIND_END, start: pos_sat,
                                       length: 16'd0, last: 1'b0};
                    scan.next_mode = sts_pkg::MODE_SKIP;
                end
            end
            sts_pkg::MODE_SKIP: begin
                if (c == sts_pkg::CH_NUL) begin
                    scan.num  = 2'd1;
                    scan.res0 = '{kind: sts_pkg::KIND_END, start: pos_sat,
                                  length: 16'd0, last: 1'b0};
                end
            end
            sts_pkg::MODE_INT, sts_pkg::MODE_SYM: begin
                if (!cont) begin
                    // close the open token, then treat the byte as fresh
                    scan.num       = idle_hit ? 2'd2 : 2'd1;
                    scan.res0      = '{kind: (i_mode == sts_pkg::MODE_INT) ? sts_pkg::KIND_INT
                                                                         : sts_pkg::KIND_SYM,
                                       start: start_sat, length: len_sat, last: 1'b0};
                    scan.res1      = idle_res;
                    scan.next_mode = idle_mode;
                    scan.set_start = idle_set;
                end
            end
            default: begin
                scan.num       = {1'b0, idle_hit};
                scan.res0      = idle_res;
                scan.next_mode = idle_mode;
                scan.set_start = idle_set;
            end
        endcase
        if (c == sts_pkg::CH_NUL) begin
            scan.next_mode = sts_pkg::MODE_IDLE;
        end
        scan.res0.last = (scan.num == 2'd1);
        scan.res1.last = 1'b1;
    end

    assign o_scan = scan;

    always_comb begin
        if (c == sts_pkg::CH_NUL) begin
            o_next_pos = '0;
        end else if (i_pos != '1) begin
            o_next_pos = i_pos + POSITION_BITS'(1);
        end else begin
            o_next_pos = i_pos;
        end
    end

endmodule

/* design/sts_checker.sv */
// ----------------------------------------------------------------------------
// sts_checker
// port-level checks on the token scanner, bound to the top level
// ----------------------------------------------------------------------------
`include "sexpr_token_scanner_macros.svh"

module sts_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [sts_pkg::TDATA_BITS-1:0] m_axis_tdata,
    input logic [2:0]                     m_axis_tuser,
    input logic                           m_axis_tlast
);

    logic [15:0] tok_len;
    logic [35:0] out_bus;
    logic        out_stall;
    logic        out_take;
    logic        end_kind;
    logic        fixed_kind;

    assign tok_len    = m_axis_tdata[31:16];
    assign out_bus    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_take   = m_axis_tvalid && m_axis_tready;
    assign end_kind   = m_axis_tvalid && (m_axis_tuser == sts_pkg::KIND_END);
    assign fixed_kind = m_axis_tvalid && (m_axis_tuser == sts_pkg::KIND_LPAREN ||
                                          m_axis_tuser == sts_pkg::KIND_RPAREN ||
                                          m_axis_tuser == sts_pkg::KIND_BOOL);

    // a stalled result item holds
    `STS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_bus))

    // an end result is empty and closes the run of its byte
    `STS_ASSERT_NOW(a_end_shape, end_kind, tok_len == 16'd0 && m_axis_tlast)

    // parens are one byte, booleans two, and both always end the run
    `STS_ASSERT_NOW(a_fixed_len, fixed_kind, m_axis_tlast && (tok_len == 16'd1 || tok_len == 16'd2))

    // the second result of a byte is queued together with the first
    `STS_ASSERT_NEXT(a_run_follows, out_take && !m_axis_tlast, m_axis_tvalid)

    // no undefined kind code on the bus
    `STS_ASSERT_NOW(a_kind_range, m_axis_tvalid, m_axis_tuser <= sts_pkg::KIND_ERROR)

endmodule

bind sexpr_token_scanner sts_checker u_sts_checker (.*);
